/* hw/rtl/bss_pkg.sv */
// ----------------------------------------------------------------------------
// bss_pkg
// shared types, codes and constants of the battery supervisor
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int SAMPLES_DEF  = 16;
	localparam int READINGS_DEF = 16;
	localparam int ADC_BITS_DEF = 12;

	localparam int FUNC_W    = 2;
	localparam int GAIN_W    = 16;
	localparam int OFFS_W    = 12;
	localparam int VOLT_W    = 14;
	localparam int WAIT_W    = 8;
	localparam int STATUS_W  = 3;
	localparam int MSG_W     = 3;
	localparam int PRESS_W   = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_TDATA_W = 32;

	localparam int VOLT_MIN     = 900;
	localparam int VOLT_MAX     = 9999;
	localparam int PRESS_REQUEST = 5;
	localparam int PRESS_FORCE  = 1000;
	localparam int PRESS_SAT    = 1023;

	localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SHUTDOWN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_BATT_REQ = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LOW       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BATT_SHDN = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REQUESTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ACTIVE    = 3'd4;

	localparam logic [MSG_W-1:0] MSG_NONE      = 3'd0;
	localparam logic [MSG_W-1:0] MSG_CONFIRM   = 3'd1;
	localparam logic [MSG_W-1:0] MSG_REQUESTED = 3'd2;
	localparam logic [MSG_W-1:0] MSG_CANCELLED = 3'd3;
	localparam logic [MSG_W-1:0] MSG_SHUTTING  = 3'd4;
	localparam logic [MSG_W-1:0] MSG_BATT_SHDN = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_VOLT_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLT_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHDN_THR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_WAIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHDN_WAIT   = 3'd5;

	typedef struct packed {
		logic [GAIN_W-1:0] volt_gain;
		logic [OFFS_W-1:0] volt_offset;
		logic [VOLT_W-1:0] low_threshold;
		logic [VOLT_W-1:0] shutdown_threshold;
		logic [WAIT_W-1:0] confirm_wait;
		logic [WAIT_W-1:0] shutdown_wait;
	} cfg_t;

	typedef struct packed {
		logic              timer_update;
		logic [WAIT_W-1:0] shutdown_count;
		logic [MSG_W-1:0]  message;
		logic              power_en;
		logic              refresh;
		logic [STATUS_W-1:0] status;
		logic [VOLT_W-1:0] voltage_cv;
	} res_t;

endpackage

/* hw/rtl/battery_supervisor_shutdown_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// battery_supervisor_shutdown_sequencer_unit
// battery supervisor with button and event driven shutdown sequencing
// ----------------------------------------------------------------------------
// One result beat leaves for every input beat. A beat is taken into an input
// register, the whole supervisor update (sample sum, gain multiply and offset,
// clamping, status, press counter, countdowns) runs in one pass from there
// into the output register, where the result is presented; a new beat is
// accepted on every clock, and only output backpressure, through the output
// register, holds the input side.
// Configuration registers are written by index through the cfg port.
module battery_supervisor_shutdown_sequencer_unit import bss_pkg::*; #(
	parameter int SAMPLES_PER_READING  = SAMPLES_DEF,
	parameter int READINGS_PER_REFRESH = READINGS_DEF,
	parameter int ADC_BITS             = ADC_BITS_DEF,
	localparam int IN_TDATA_W          = ((ADC_BITS + 1 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // adc_sample, button_pressed
	input  logic [FUNC_W-1:0]      s_tuser,   // func
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // voltage_cv, status, refresh, power_en,
	                                          // message, shutdown_count, timer_update
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic                s1_valid_q;
	logic [FUNC_W-1:0]   func_s1;
	logic [ADC_BITS-1:0] adc_s1;
	logic                btn_s1;
	logic                m_valid_q;
	res_t                res_q;
	res_t                res;
	cfg_t                cfg;
	logic                advance;

	assign advance  = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			adc_s1  <= s_tdata[ADC_BITS-1:0];
			btn_s1  <= s_tdata[ADC_BITS];
		end
	end

	bss_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	bss_core #(
		.SAMPLES_PER_READING  (SAMPLES_PER_READING),
		.READINGS_PER_REFRESH (READINGS_PER_REFRESH),
		.ADC_BITS             (ADC_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.func           (func_s1),
		.adc_sample     (adc_s1),
		.button_pressed (btn_s1),
		.cfg            (cfg),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'(res_q);

`ifndef SYNTHESIS
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(func_s1) && $stable(adc_s1))
		else $error("input stage lost a beat");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q)
		else $error("processed beat produced no result");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");
`endif

endmodule

/* hw/rtl/bss_cfg.sv */
// ----------------------------------------------------------------------------
// bss_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module bss_cfg import bss_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volt_gain          <= GAIN_W'(1300);
			cfg_q.volt_offset        <= OFFS_W'(250);
			cfg_q.low_threshold      <= VOLT_W'(1100);
			cfg_q.shutdown_threshold <= VOLT_W'(1000);
			cfg_q.confirm_wait       <= WAIT_W'(3);
			cfg_q.shutdown_wait      <= WAIT_W'(10);
		end else if (we) begin
			unique case (index)
				REG_VOLT_GAIN:    cfg_q.volt_gain          <= wdata[GAIN_W-1:0];
				REG_VOLT_OFFSET:  cfg_q.volt_offset        <= wdata[OFFS_W-1:0];
				REG_LOW_THR:      cfg_q.low_threshold      <= wdata[VOLT_W-1:0];
				REG_SHDN_THR:     cfg_q.shutdown_threshold <= wdata[VOLT_W-1:0];
				REG_CONFIRM_WAIT: cfg_q.confirm_wait       <= wdata[WAIT_W-1:0];
				REG_SHDN_WAIT:    cfg_q.shutdown_wait      <= wdata[WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/bss_core.sv */
// ----------------------------------------------------------------------------
// bss_core
// supervisor state and single-pass update: averaging, scaling, status,
// button press handling, shutdown and battery shutdown requests and refresh countdowns
// ----------------------------------------------------------------------------
module bss_core import bss_pkg::*; #(
	parameter int SAMPLES_PER_READING  = SAMPLES_DEF,
	parameter int READINGS_PER_REFRESH = READINGS_DEF,
	parameter int ADC_BITS             = ADC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [FUNC_W-1:0]   func,
	input  logic [ADC_BITS-1:0] adc_sample,
	input  logic                button_pressed,
	input  cfg_t                cfg,
	output res_t                res
);

	localparam int SUM_W  = ADC_BITS + $clog2(SAMPLES_PER_READING);
	localparam int SC_W   = $clog2(SAMPLES_PER_READING);
	localparam int RC_W   = (READINGS_PER_REFRESH > 1) ? $clog2(READINGS_PER_REFRESH) : 1;
	localparam int PROD_W = SUM_W + GAIN_W;
	localparam int V_W    = ((SUM_W > OFFS_W) ? SUM_W : OFFS_W) + 1;

	logic [SUM_W-1:0]    sample_sum_q,     sample_sum_d;
	logic [SC_W-1:0]     sample_count_q,   sample_count_d;
	logic [RC_W-1:0]     reading_count_q,  reading_count_d;
	logic [VOLT_W-1:0]   voltage_q,        voltage_d;
	logic [STATUS_W-1:0] status_q,         status_d;
	logic [PRESS_W-1:0]  press_count_q,    press_count_d;
	logic [WAIT_W-1:0]   confirm_count_q,  confirm_count_d;
	logic [WAIT_W-1:0]   shutdown_cnt_q,   shutdown_cnt_d;
	logic                power_hold_q,     power_hold_d;

	logic [SUM_W-1:0]    sum_add;
	logic [PROD_W-1:0]   prod;
	logic [V_W-1:0]      scaled;
	logic [VOLT_W-1:0]   volt_new;
	logic                reading_done;
	logic                refresh_hit;
	logic                refresh;
	logic                tupd;
	logic [WAIT_W-1:0]   tcount;
	logic [MSG_W-1:0]    message;

	assign sum_add      = sample_sum_q + SUM_W'(adc_sample);
	assign prod         = PROD_W'(sum_add) * PROD_W'(cfg.volt_gain);
	assign scaled       = V_W'(prod >> GAIN_W) + V_W'(cfg.volt_offset);
	assign reading_done = (sample_count_q == SC_W'(SAMPLES_PER_READING - 1));
	assign refresh_hit  = reading_done && (reading_count_q == RC_W'(READINGS_PER_REFRESH - 1));

	always_comb begin
		if (32'(scaled) > 32'(VOLT_MAX)) begin
			volt_new = VOLT_W'(VOLT_MAX);
		end else if (32'(scaled) < 32'(VOLT_MIN)) begin
			volt_new = '0;
		end else begin
			volt_new = VOLT_W'(scaled);
		end
	end

	always_comb begin
		sample_sum_d    = sample_sum_q;
		sample_count_d  = sample_count_q;
		reading_count_d = reading_count_q;
		voltage_d       = voltage_q;
		status_d        = status_q;
		press_count_d   = press_count_q;
		confirm_count_d = confirm_count_q;
		shutdown_cnt_d  = shutdown_cnt_q;
		power_hold_d    = power_hold_q;
		refresh         = 1'b0;
		tupd            = 1'b0;
		tcount          = '0;
		message         = MSG_NONE;

		case (func)
			FUNC_TICK: begin
				if (reading_done) begin
					sample_count_d  = '0;
					sample_sum_d    = '0;
					voltage_d       = volt_new;
					reading_count_d = refresh_hit ? '0 : reading_count_q + RC_W'(1);
					if (status_q < ST_REQUESTED) begin
						if (volt_new > cfg.low_threshold) begin
							status_d = ST_OK;
						end else if (volt_new > cfg.shutdown_threshold) begin
							status_d = ST_LOW;
						end else begin
							status_d = ST_BATT_SHDN;
						end
					end
				end else begin
					sample_count_d = sample_count_q + SC_W'(1);
					sample_sum_d   = sum_add;
				end

				if (button_pressed) begin
					if (press_count_q < PRESS_W'(PRESS_SAT)) begin
						press_count_d = press_count_q + PRESS_W'(1);
					end
					if (press_count_d == PRESS_W'(PRESS_REQUEST)) begin
						if (confirm_count_q == '0) begin
							message = MSG_CONFIRM;
						end else begin
							status_d = ST_REQUESTED;
							message  = MSG_REQUESTED;
						end
						confirm_count_d = cfg.confirm_wait;
					end else if (press_count_d == PRESS_W'(PRESS_FORCE)) begin
						power_hold_d = 1'b0;
					end
				end else begin
					press_count_d = '0;
				end

				if (refresh_hit) begin
					refresh = 1'b1;
					if (status_d != ST_ACTIVE && !button_pressed && confirm_count_d != '0) begin
						confirm_count_d = confirm_count_d - WAIT_W'(1);
						if (confirm_count_d == '0) begin
							message  = MSG_CANCELLED;
							status_d = ST_OK;
						end
					end
					if (shutdown_cnt_q != '0) begin
						shutdown_cnt_d = shutdown_cnt_q - WAIT_W'(1);
						tupd           = 1'b1;
						tcount         = shutdown_cnt_d;
						if (shutdown_cnt_d == '0) begin
							power_hold_d = 1'b0;
						end
					end
				end
			end
			FUNC_SHUTDOWN: begin
				status_d       = ST_ACTIVE;
				shutdown_cnt_d = cfg.shutdown_wait;
				message        = MSG_SHUTTING;
			end
			FUNC_BATT_REQ: begin
				status_d        = ST_REQUESTED;
				message         = MSG_BATT_SHDN;
				confirm_count_d = cfg.confirm_wait;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_sum_q    <= '0;
			sample_count_q  <= '0;
			reading_count_q <= '0;
			voltage_q       <= '0;
			status_q        <= ST_OK;
			press_count_q   <= '0;
			confirm_count_q <= '0;
			shutdown_cnt_q  <= '0;
			power_hold_q    <= 1'b1;
		end else if (en) begin
			sample_sum_q    <= sample_sum_d;
			sample_count_q  <= sample_count_d;
			reading_count_q <= reading_count_d;
			voltage_q       <= voltage_d;
			status_q        <= status_d;
			press_count_q   <= press_count_d;
			confirm_count_q <= confirm_count_d;
			shutdown_cnt_q  <= shutdown_cnt_d;
			power_hold_q    <= power_hold_d;
		end
	end

	assign res.voltage_cv     = voltage_d;
	assign res.status         = status_d;
	assign res.refresh        = refresh;
	assign res.power_en       = power_hold_d;
	assign res.message        = message;
	assign res.shutdown_count = tcount;
	assign res.timer_update   = tupd;

`ifndef SYNTHESIS
	a_power_cut_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!power_hold_q |=> !power_hold_q)
		else $error("power hold came back after cut");

	a_count_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		!res.timer_update |-> res.shutdown_count == '0)
		else $error("shutdown count shown without a step");

	a_refresh_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.refresh |=> sample_count_q == '0 && reading_count_q == '0)
		else $error("refresh did not wrap the counters");
`endif

endmodule
